// ===== rtl/cgl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers for the colour gradient lookup.
// Used by cgl_divider and color_gradient_lookup_top; depends on nothing.
package cgl_pkg;

	localparam int CHAN_W     = 8;                      // bits per colour channel
	localparam int POS_W      = 8;                      // gradient position bits
	localparam int NUM_CH     = 4;                      // red, green, blue, alpha
	localparam int MAX_MARKS  = 7;
	localparam int COUNT_W    = 3;
	localparam int MARK_W     = POS_W + NUM_CH * CHAN_W;
	localparam int COLOR_W    = NUM_CH * CHAN_W;
	localparam int CFG_IDX_W  = 4;
	// lc*d + (uc-lc)*t + d/2 stays below 2^CHAN_W * d
	localparam int ACC_W      = POS_W + CHAN_W;
	localparam int PROD_A_W   = CHAN_W + POS_W;
	localparam int PROD_B_W   = CHAN_W + POS_W + 2;
	localparam int SUM_W      = PROD_B_W + 1;
	localparam int DIV_STAGES = CHAN_W;                 // one quotient bit per stage

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MARK_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MARK_BASE  = CFG_IDX_W'(1);

	typedef logic [MARK_W-1:0]  mark_t;
	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [ACC_W-1:0]   acc_t;

	// colour in output order, channel 0 (red) in the low bits
	typedef chan_t [NUM_CH-1:0] color_t;
	typedef acc_t  [NUM_CH-1:0] acc_vec_t;

	// travels alongside the divider: bypass colour for the cases where either mark is missing
	typedef struct packed {
		logic   use_pass;
		color_t pass;
	} cgl_side_t;

	function automatic pos_t mark_pos(input mark_t m);
		mark_pos = m[MARK_W-1 -: POS_W];
	endfunction

	// channel k: 0 red, 1 green, 2 blue, 3 alpha
	function automatic chan_t mark_chan(input mark_t m, input int k);
		mark_chan = m[(NUM_CH-1-k)*CHAN_W +: CHAN_W];
	endfunction

endpackage

// ===== rtl/cgl_divider.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, four channels sharing one divisor, one
// quotient bit per stage. Depends on cgl_pkg.
module cgl_divider import cgl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  acc_vec_t  in_rem,
	input  pos_t      in_d,
	input  cgl_side_t in_side,
	output logic      out_valid,
	input  logic      out_ready,
	output color_t    out_quot,
	output cgl_side_t out_side
);

	logic      valid_s [DIV_STAGES];
	acc_vec_t  rem_s   [DIV_STAGES];
	color_t    quot_s  [DIV_STAGES];
	pos_t      d_s     [DIV_STAGES];
	cgl_side_t side_s  [DIV_STAGES];

	// what each stage takes in: the ports for stage 0, the previous stage otherwise
	logic      valid_in [DIV_STAGES];
	acc_vec_t  rem_in   [DIV_STAGES];
	color_t    quot_in  [DIV_STAGES];
	pos_t      d_in     [DIV_STAGES];
	cgl_side_t side_in  [DIV_STAGES];

	acc_vec_t  rem_nx  [DIV_STAGES];
	color_t    quot_nx [DIV_STAGES];
	logic [DIV_STAGES:0] en;

	always_comb begin
		valid_in[0] = in_valid;
		rem_in[0]   = in_rem;
		quot_in[0]  = '0;
		d_in[0]     = in_d;
		side_in[0]  = in_side;
		for (int k = 1; k < DIV_STAGES; k++) begin
			valid_in[k] = valid_s[k-1];
			rem_in[k]   = rem_s[k-1];
			quot_in[k]  = quot_s[k-1];
			d_in[k]     = d_s[k-1];
			side_in[k]  = side_s[k-1];
		end
	end

	// stage stalls only when it is full and the next one will not move
	always_comb begin
		en[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			en[k] = ~valid_s[k] | en[k+1];
		end
	end

	assign in_ready = en[0];

	always_comb begin
		acc_t  prev_rem;
		chan_t prev_q;
		acc_t  trial;
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				prev_rem = rem_in[k][ch];
				prev_q   = quot_in[k][ch];
				trial    = ACC_W'(d_in[k]) << (DIV_STAGES - 1 - k);
				if (prev_rem >= trial) begin
					rem_nx[k][ch]  = prev_rem - trial;
					quot_nx[k][ch] = prev_q | (CHAN_W'(1) << (DIV_STAGES - 1 - k));
				end else begin
					rem_nx[k][ch]  = prev_rem;
					quot_nx[k][ch] = prev_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (en[k]) begin
				rem_s[k]  <= rem_nx[k];
				quot_s[k] <= quot_nx[k];
				d_s[k]    <= d_in[k];
				side_s[k] <= side_in[k];
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_quot  = quot_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

// ===== rtl/color_gradient_lookup_top.sv =====
`timescale 1ns / 1ps
// Colour gradient lookup: 8-bit position in, interpolated RGBA8 out.
// Depends on cgl_pkg and cgl_divider.
//
// One position is accepted every clock unless the pipeline is stalled, and
// one RGBA colour comes out per item, in order, through 13 register stages
// (mark compares, mark search, products, sum, eight divider stages that each
// resolve one quotient bit, output register).
// Backpressure on the output stalls the pipeline only where
// stages are full, so bubbles are squeezed out. Marks and mark_count are
// written through the cfg port (index 0 count, 1..7 marks, others ignored)
// and must only change while no item is in flight.
module color_gradient_lookup_top import cgl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MARK_W-1:0]    cfg_data,
	// input items
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [POS_W-1:0]     s_axis_tdata,   // [7:0] sample_position
	// result items
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [COLOR_W-1:0]   m_axis_tdata    // [7:0] red, [15:8] green,
	                                             // [23:16] blue, [31:24] alpha
);

	// ---------------- configuration registers ----------------
	logic [COUNT_W-1:0] count_q;
	mark_t              mark_q [MAX_MARKS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_MARKS; i++) begin
				mark_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_MARK_COUNT) begin
				count_q <= cfg_data[COUNT_W-1:0];
			end
			for (int i = 0; i < MAX_MARKS; i++) begin
				if (cfg_index == REG_MARK_BASE + CFG_IDX_W'(i)) begin
					mark_q[i] <= cfg_data;
				end
			end
		end
	end

	// ---------------- handshake chain ----------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4, en_out;
	logic div_in_ready, div_out_valid;

	assign en_out        = ~m_axis_tvalid | m_axis_tready;
	assign en4           = ~v_s4 | div_in_ready;
	assign en3           = ~v_s3 | en4;
	assign en2           = ~v_s2 | en3;
	assign en1           = ~v_s1 | en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: compare every mark against the position ----------------
	pos_t                 p_s1;
	logic [MAX_MARKS-1:0] below_s1, above_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			p_s1 <= s_axis_tdata;
			for (int i = 0; i < MAX_MARKS; i++) begin
				below_s1[i] <= (COUNT_W'(i) < count_q) &&
				               (mark_pos(mark_q[i]) <  s_axis_tdata);
				above_s1[i] <= (COUNT_W'(i) < count_q) &&
				               (mark_pos(mark_q[i]) >= s_axis_tdata);
			end
		end
	end

	// ---------------- stage 2: pick lower and upper marks ----------------
	mark_t lo_m, hi_m;
	logic  hlo, hhi;

	// strict compares keep the lower index on equal positions
	always_comb begin
		lo_m = '0;
		hi_m = '0;
		hlo  = 1'b0;
		hhi  = 1'b0;
		for (int i = 0; i < MAX_MARKS; i++) begin
			if (below_s1[i] && (!hlo || mark_pos(lo_m) < mark_pos(mark_q[i]))) begin
				lo_m = mark_q[i];
				hlo  = 1'b1;
			end
			if (above_s1[i] && (!hhi || mark_pos(hi_m) > mark_pos(mark_q[i]))) begin
				hi_m = mark_q[i];
				hhi  = 1'b1;
			end
		end
	end

	mark_t lo_s2, hi_s2;
	logic  have_lo_s2, have_hi_s2;
	pos_t  p_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			lo_s2      <= lo_m;
			hi_s2      <= hi_m;
			have_lo_s2 <= hlo;
			have_hi_s2 <= hhi;
			p_s2       <= p_s1;
		end
	end

	// ---------------- stage 3: span, offset and products ----------------
	pos_t      lo_pos_s2, hi_pos_s2, d_nx, t_nx;
	cgl_side_t side_nx;

	assign lo_pos_s2 = mark_pos(lo_s2);
	assign hi_pos_s2 = mark_pos(hi_s2);
	assign d_nx      = hi_pos_s2 - lo_pos_s2;
	assign t_nx      = p_s2 - lo_pos_s2;

	always_comb begin
		side_nx.use_pass = ~(have_lo_s2 & have_hi_s2);
		for (int k = 0; k < NUM_CH; k++) begin
			if (have_lo_s2) begin
				side_nx.pass[k] = mark_chan(lo_s2, k);
			end else if (have_hi_s2) begin
				side_nx.pass[k] = mark_chan(hi_s2, k);
			end else begin
				side_nx.pass[k] = '0;
			end
		end
	end

	logic [PROD_A_W-1:0]        prod_a_s3 [NUM_CH];
	logic signed [PROD_B_W-1:0] prod_b_s3 [NUM_CH];
	pos_t                       d_s3;
	cgl_side_t                  side_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int k = 0; k < NUM_CH; k++) begin
				prod_a_s3[k] <= PROD_A_W'(mark_chan(lo_s2, k)) * PROD_A_W'(d_nx);
				prod_b_s3[k] <= PROD_B_W'($signed({1'b0, mark_chan(hi_s2, k)}) -
				                          $signed({1'b0, mark_chan(lo_s2, k)})) *
				                PROD_B_W'($signed({1'b0, t_nx}));
			end
			d_s3    <= d_nx;
			side_s3 <= side_nx;
		end
	end

	// ---------------- stage 4: accumulate with rounding term ----------------
	acc_vec_t  acc_nx;
	logic signed [SUM_W-1:0] sum;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			sum = $signed(SUM_W'(prod_a_s3[k])) + SUM_W'(prod_b_s3[k]) +
			      $signed(SUM_W'(d_s3 >> 1));
			acc_nx[k] = sum[ACC_W-1:0];
		end
	end

	acc_vec_t  acc_s4;
	pos_t      d_s4;
	cgl_side_t side_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			acc_s4  <= acc_nx;
			d_s4    <= d_s3;
			side_s4 <= side_s3;
		end
	end

	// ---------------- divide and output register ----------------
	color_t    quot;
	cgl_side_t side_div;

	cgl_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.in_rem    (acc_s4),
		.in_d      (d_s4),
		.in_side   (side_s4),
		.out_valid (div_out_valid),
		.out_ready (en_out),
		.out_quot  (quot),
		.out_side  (side_div)
	);

	logic   out_valid_q;
	color_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_data_q <= side_div.use_pass ? side_div.pass : quot;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- assertions ----------------
	logic acc_ok_s4;

	always_comb begin
		acc_ok_s4 = 1'b1;
		for (int k = 0; k < NUM_CH; k++) begin
			if (acc_s4[k] >= (ACC_W'(d_s4) << CHAN_W)) begin
				acc_ok_s4 = 1'b0;
			end
		end
	end

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_mark_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && have_lo_s2 && have_hi_s2 |-> lo_pos_s2 < hi_pos_s2)
		else $error("lower mark not below upper mark");

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !side_s3.use_pass |-> d_s3 != '0)
		else $error("zero span on interpolated item");

	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !side_s4.use_pass |-> acc_ok_s4)
		else $error("accumulator would overflow quotient width");

endmodule
